// File: hw/rtl/dttq_pkg.sv
// Package for the delayed task timer queue: op and result codes, sequencer states,
// and the bus that runs along the row of slot cells. No dependencies.
package dttq_pkg;

    localparam int ID_BITS = 32;
    localparam int TPU_BITS = 16;
    localparam int DELAY_BITS = 16;
    localparam int MAX_RESULTS = 16;
    localparam logic [TPU_BITS-1:0] TPU_RESET = 16'd1000;

    typedef enum logic [1:0] {
        OP_SCHED  = 2'd0,
        OP_CANCEL = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_ID   = 2'd0,
        KIND_FULL = 2'd1,
        KIND_FIRE = 2'd2,
        KIND_RSVD = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SCAN,
        ST_PICK,
        ST_OUT,
        ST_DONE
    } state_t;

    // Control that every cell sees in a cycle.
    typedef struct packed {
        logic          clear_scan;  // start a fresh scan
        logic          scan;        // shift the candidate one cell along
        logic          cancel;      // drop entries with a matching id
        logic [ID_BITS-1:0] cancel_id;
        logic [ID_BITS-1:0] next_id;
    } cell_ctl_t;

endpackage

// File: hw/rtl/dttq_cell.sv
// One slot of the timer queue: valid bit, id and target; the id is its sequence number.
// Passes the best due candidate seen so far to its neighbor. Uses dttq_pkg.
module dttq_cell
    import dttq_pkg::*;
#(
    parameter int TIME_BITS = 40,
    parameter int IDX_BITS  = 4,
    parameter logic [IDX_BITS-1:0] INDEX = '0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cell_ctl_t            ctl,
    input  logic [TIME_BITS-1:0] now_ticks,
    input  logic                 wr_en,
    input  logic [ID_BITS-1:0]   wr_id,
    input  logic [TIME_BITS-1:0] wr_target,
    input  logic                 kill,
    // candidate chain
    input  logic                 in_found,
    input  logic [IDX_BITS-1:0]  in_idx,
    input  logic [TIME_BITS-1:0] in_late,
    input  logic [ID_BITS-1:0]   in_age,
    input  logic [ID_BITS-1:0]   in_id,
    output logic                 out_found,
    output logic [IDX_BITS-1:0]  out_idx,
    output logic [TIME_BITS-1:0] out_late,
    output logic [ID_BITS-1:0]   out_age,
    output logic [ID_BITS-1:0]   out_id,
    output logic                 valid
);

    logic                 valid_reg, valid_next;
    logic [ID_BITS-1:0]   id_reg;
    logic [TIME_BITS-1:0] target_reg;
    logic                 found_reg, found_next;
    logic [IDX_BITS-1:0]  idx_reg, idx_next;
    logic [TIME_BITS-1:0] late_reg, late_next;
    logic [ID_BITS-1:0]   age_reg, age_next;
    logic [ID_BITS-1:0]   cid_reg, cid_next;
    logic [TIME_BITS-1:0] late;
    logic [ID_BITS-1:0]   age;
    logic                 due, better;

    assign late = now_ticks - target_reg;
    assign age  = ctl.next_id - id_reg;
    assign due  = valid_reg && (late != '0) && !late[TIME_BITS-1];
    assign better = !in_found || (late > in_late) || (late == in_late && age > in_age);

    always_comb begin
        valid_next = valid_reg;
        if (ctl.cancel && id_reg == ctl.cancel_id) valid_next = 1'b0;
        if (kill) valid_next = 1'b0;
        if (wr_en) valid_next = 1'b1;
        found_next = found_reg;
        idx_next   = idx_reg;
        late_next  = late_reg;
        age_next   = age_reg;
        cid_next   = cid_reg;
        if (ctl.clear_scan) begin
            found_next = 1'b0;
        end else if (ctl.scan) begin
            if (due && better) begin
                found_next = 1'b1;
                idx_next   = INDEX;
                late_next  = late;
                age_next   = age;
                cid_next   = id_reg;
            end else begin
                found_next = in_found;
                idx_next   = in_idx;
                late_next  = in_late;
                age_next   = in_age;
                cid_next   = in_id;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            found_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            found_reg <= found_next;
        end
        idx_reg  <= idx_next;
        late_reg <= late_next;
        age_reg  <= age_next;
        cid_reg  <= cid_next;
        if (wr_en) begin
            id_reg     <= wr_id;
            target_reg <= wr_target;
        end
    end

    assign out_found = found_reg;
    assign out_idx   = idx_reg;
    assign out_late  = late_reg;
    assign out_age   = age_reg;
    assign out_id    = cid_reg;
    assign valid     = valid_reg;

endmodule

// File: hw/rtl/delayed_task_timer_queue.sv
// Delayed task timer queue top level: sequencer, target multiplier, row of
// dttq_cell slots. Uses dttq_pkg.
//
// Usage: items enter on s_axis (op, delay_units, cancel_id). Schedule answers
// with one result (id assigned, or full). Cancel drops matching entries and
// answers nothing. Tick advances the time by one and emits up to MAX_RESULTS due
// tasks, oldest target first, ties by scheduling order, last marked on the final one.
// The config channel writes ticks_per_unit (1000 after reset) while idle.
// A schedule waits for the registered product, then writes a free slot and answers.
// A tick sweeps the candidate down the chain of CAPACITY cells for each fired task,
// and once for a tick with none due.
// One item is in flight at a time; s_axis_tready is high only when idle.
// Results sit in an output register; while m_axis_tready is low the block
// holds and the next scan waits. Reset clears all slots, time and id counter.
module delayed_task_timer_queue
    import dttq_pkg::*;
#(
    parameter int CAPACITY  = 16,
    parameter int TIME_BITS = 40
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] op, [17:2] delay_units, [49:18] cancel_id
    input  logic [55:0] s_axis_tdata,
    input  logic        m_axis_tready,
    output logic        m_axis_tvalid,
    // [31:0] task_id
    output logic [31:0] m_axis_tdata,
    // [1:0] kind
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    localparam int IDX_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_BITS = $clog2(CAPACITY + 2);
    localparam int RES_BITS = $clog2(MAX_RESULTS + 1);

    state_t state_reg, state_next;
    logic [TPU_BITS-1:0]  tpu_reg;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [ID_BITS-1:0]   nid_reg, nid_next;
    logic [ID_BITS-1:0]   cid_reg;
    logic [DELAY_BITS-1:0] delay_reg;
    logic [31:0]          prod_reg;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [RES_BITS-1:0]  nres_reg, nres_next;
    logic                 ov_reg, ov_next;
    logic [1:0]           okind_reg, okind_next;
    logic [ID_BITS-1:0]   oid_reg, oid_next;
    logic                 olast_reg, olast_next;
    logic                 cancel_pulse;
    logic                 wr_any;
    logic [IDX_BITS-1:0]  free_idx;
    logic                 free_any;
    logic                 kill_any;
    logic [IDX_BITS-1:0]  kill_idx;
    cell_ctl_t            ctl;

    logic                 c_found [CAPACITY+1];
    logic [IDX_BITS-1:0]  c_idx   [CAPACITY+1];
    logic [TIME_BITS-1:0] c_late  [CAPACITY+1];
    logic [ID_BITS-1:0]   c_age   [CAPACITY+1];
    logic [ID_BITS-1:0]   c_id    [CAPACITY+1];
    logic [CAPACITY-1:0]  vbits;
    logic [TIME_BITS-1:0] tgt;

    assign c_found[0] = 1'b0;
    assign c_idx[0]   = '0;
    assign c_late[0]  = '0;
    assign c_age[0]   = '0;
    assign c_id[0]    = '0;

    // first free slot, lowest index wins
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!vbits[i]) begin
                free_any = 1'b1;
                free_idx = IDX_BITS'(i);
            end
        end
    end

    assign tgt = now_reg + TIME_BITS'(prod_reg);
    assign ctl.clear_scan = (state_reg == ST_IDLE) || (state_reg == ST_PICK);
    assign ctl.scan      = (state_reg == ST_SCAN);
    assign ctl.cancel    = cancel_pulse;
    assign ctl.cancel_id = cid_reg;
    assign ctl.next_id   = nid_reg;
    assign kill_idx      = c_idx[CAPACITY];

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            dttq_cell #(
                .TIME_BITS(TIME_BITS),
                .IDX_BITS (IDX_BITS),
                .INDEX    (IDX_BITS'(g))
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctl      (ctl),
                .now_ticks(now_reg),
                .wr_en    (wr_any && free_idx == IDX_BITS'(g)),
                .wr_id    (nid_reg),
                .wr_target(tgt),
                .kill     (kill_any && kill_idx == IDX_BITS'(g)),
                .in_found (c_found[g]),
                .in_idx   (c_idx[g]),
                .in_late  (c_late[g]),
                .in_age   (c_age[g]),
                .in_id    (c_id[g]),
                .out_found(c_found[g+1]),
                .out_idx  (c_idx[g+1]),
                .out_late (c_late[g+1]),
                .out_age  (c_age[g+1]),
                .out_id   (c_id[g+1]),
                .valid    (vbits[g])
            );
        end
    endgenerate

    assign s_axis_tready = (state_reg == ST_IDLE) && !ov_reg;
    assign cfg_ready     = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        now_next     = now_reg;
        nid_next     = nid_reg;
        cnt_next     = cnt_reg;
        nres_next    = nres_reg;
        ov_next      = ov_reg;
        okind_next   = okind_reg;
        oid_next     = oid_reg;
        olast_next   = olast_reg;
        cancel_pulse = 1'b0;
        wr_any       = 1'b0;
        kill_any     = 1'b0;
        if (ov_reg && m_axis_tready) ov_next = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    case (op_t'(s_axis_tdata[1:0]))
                        OP_SCHED: begin
                            cnt_next   = '0;
                            state_next = ST_MUL;
                        end
                        OP_CANCEL: state_next = ST_DONE;
                        OP_TICK: begin
                            now_next   = now_reg + TIME_BITS'(1);
                            nres_next  = '0;
                            cnt_next   = '0;
                            olast_next = 1'b0;
                            state_next = ST_SCAN;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MUL: begin
                // wait for the registered product, then write the slot and answer once the output register is free
                if (cnt_reg == '0) begin
                    cnt_next = CNT_BITS'(1);
                end else if (!ov_reg) begin
                    ov_next = 1'b1;
                    olast_next = 1'b1;
                    if (free_any) begin
                        wr_any     = 1'b1;
                        okind_next = KIND_ID;
                        oid_next   = nid_reg;
                        nid_next   = nid_reg + ID_BITS'(1);
                    end else begin
                        okind_next = KIND_FULL;
                        oid_next   = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                cnt_next = cnt_reg + CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(CAPACITY - 1)) state_next = ST_PICK;
            end
            ST_PICK: begin
                // candidate at chain end is final
                if (!c_found[CAPACITY]) begin
                    if (nres_reg != '0) olast_next = 1'b1;
                    state_next = (nres_reg != '0) ? ST_OUT : ST_IDLE;
                    if (nres_reg != '0) ov_next = 1'b1;
                end else if (!ov_reg || m_axis_tready) begin
                    // hand previous held item over, then stage this one
                    kill_any = 1'b1;
                    if (nres_reg != '0) ov_next = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                state_next = ST_OUT;
                if (olast_reg) begin
                    if (!ov_reg) state_next = ST_IDLE;
                end else if (!ov_reg || m_axis_tready) begin
                    // pending fired item becomes the held one
                    okind_next = KIND_FIRE;
                    oid_next   = c_id[CAPACITY];
                    olast_next = 1'b0;
                    nres_next  = nres_reg + RES_BITS'(1);
                    ov_next    = 1'b0;
                    cnt_next   = '0;
                    state_next = (nres_reg + RES_BITS'(1) == RES_BITS'(MAX_RESULTS))
                        ? ST_OUT : ST_SCAN;
                    if (nres_reg + RES_BITS'(1) == RES_BITS'(MAX_RESULTS)) begin
                        olast_next = 1'b1;
                        ov_next    = 1'b1;
                    end
                end
            end
            ST_DONE: begin
                cancel_pulse = !olast_reg || !ov_reg;
                if (!ov_reg) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            tpu_reg   <= TPU_RESET;
            now_reg   <= '0;
            nid_reg   <= '0;
            ov_reg    <= 1'b0;
            olast_reg <= 1'b0;
            cnt_reg   <= '0;
            nres_reg  <= '0;
        end else begin
            state_reg <= state_next;
            now_reg   <= now_next;
            nid_reg   <= nid_next;
            ov_reg    <= ov_next;
            olast_reg <= olast_next;
            cnt_reg   <= cnt_next;
            nres_reg  <= nres_next;
            if (cfg_valid && cfg_ready) tpu_reg <= cfg_data;
        end
        okind_reg <= okind_next;
        oid_reg   <= oid_next;
        if (s_axis_tvalid && s_axis_tready) begin
            delay_reg <= s_axis_tdata[17:2];
            cid_reg   <= s_axis_tdata[49:18];
        end
        prod_reg <= delay_reg * tpu_reg;
    end

    // fired items wait in the output register one step behind the scan
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = oid_reg;
    assign m_axis_tuser  = okind_reg;
    assign m_axis_tlast  = olast_reg;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> state_reg == ST_IDLE)
        else $error("input taken while busy");
    a_nid: assert property (@(posedge aclk) disable iff (!aresetn)
        nid_reg != $past(nid_reg) |-> $past(state_reg) == ST_MUL)
        else $error("id counter moved outside schedule");

endmodule
